// ----- src/ptq_pkg.sv -----
package ptq_pkg;

  localparam int TABLE_SIZE_DEF = 65536;
  localparam int MODE_W = 3;
  localparam int VAL_W = 16;
  localparam int ANS_W = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int NEAR_LIMIT = 131071;

  localparam logic [MODE_W-1:0] MODE_RANGE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ISPRIME = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEAR = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BELOW = 3'd5;

  typedef enum logic [2:0] {
    OP_RANGE,
    OP_DIV,
    OP_ISPRIME,
    OP_REV,
    OP_NEAR,
    OP_BELOW,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } query_t;

  typedef enum logic [4:0] {
    ST_FILL,
    ST_SRD,
    ST_SCHK,
    ST_SMARK,
    ST_IDLE,
    ST_CNT,
    ST_DCHK,
    ST_DDIV,
    ST_DRES,
    ST_PCHK,
    ST_REV,
    ST_RRD,
    ST_NK,
    ST_NLO,
    ST_NHI,
    ST_NCHK,
    ST_EMIT
  } state_t;

endpackage

// ----- src/ptq_front.sv -----
module ptq_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ptq_pkg::MODE_W-1:0] mode,
  input  logic [ptq_pkg::VAL_W-1:0]  first_value,
  input  logic [ptq_pkg::VAL_W-1:0]  second_value,
  output logic                   q_valid,
  input  logic                   q_ready,
  output ptq_pkg::query_t        query
);
  import ptq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  query_t          slot [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  query_t          cls;
  logic            push;
  logic            pop;

  // Classify the query; a range is normalized so that a is the lower end.
  always_comb begin
    cls.a = first_value;
    cls.b = second_value;
    unique case (mode)
      MODE_RANGE: begin
        cls.op = OP_RANGE;
        if (first_value > second_value) begin
          cls.a = second_value;
          cls.b = first_value;
        end
      end
      MODE_DIV:     cls.op = OP_DIV;
      MODE_ISPRIME: cls.op = OP_ISPRIME;
      MODE_REV:     cls.op = OP_REV;
      MODE_NEAR:    cls.op = OP_NEAR;
      MODE_BELOW:   cls.op = OP_BELOW;
      default:      cls.op = OP_NONE;
    endcase
  end

  assign in_ready = (count != (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign query = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- src/ptq_back.sv -----
module ptq_back #(
  parameter int TABLE_SIZE = ptq_pkg::TABLE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  ptq_pkg::query_t            query,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ptq_pkg::ANS_W-1:0]  answer,
  output logic                       last,
  output logic                       out_of_range
);
  import ptq_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int VW = ((AW > ANS_W) ? AW : ANS_W) + 1;
  localparam logic [VW-1:0] TS_V = VW'(TABLE_SIZE);
  localparam logic [VW-1:0] TS_LAST = VW'(TABLE_SIZE - 1);
  localparam logic [ANS_W-1:0] NEAR_LAST = ANS_W'(NEAR_LIMIT);

  logic mem [TABLE_SIZE];
  logic rdata;

  state_t state, state_next;

  logic [VW-1:0]    cur;
  logic [VW-1:0]    lim;
  logic [VW-1:0]    sq;
  logic [VW-1:0]    m;
  logic [VW-1:0]    kv;
  logic [VAL_W-1:0] ka;
  logic             pend;
  logic [ANS_W-1:0] acc;
  logic [8:0]       dv;
  logic [8:0]       rem;
  logic [3:0]       bitn;
  logic [VAL_W-1:0] tdig;
  logic [ANS_W-1:0] rev;
  logic [ANS_W-1:0] step;
  logic             lof;
  logic [ANS_W-1:0] res_ans;
  logic             res_last;
  logic             res_oor;
  logic             has2;
  logic [ANS_W-1:0] ans2;

  logic             we;
  logic [VW-1:0]    wa;
  logic             wd;
  logic [VW-1:0]    ra;

  logic [VW-1:0]    lo_v;
  logic [VW-1:0]    hi_v;
  logic             lo_ok;
  logic             hi_p;
  logic             cnt_go;
  logic [9:0]       r2;
  logic [32:0]      prod;
  logic [VAL_W-1:0] quo;
  logic [3:0]       digit;
  logic [20:0]      rev_w;
  logic [VW-1:0]    rev_v;
  logic             emit_go;

  assign lo_v = kv - VW'(step);
  assign hi_v = kv + VW'(step);
  assign lo_ok = (kv >= VW'(step)) && (lo_v < TS_V);
  assign hi_p = (hi_v < TS_V) && rdata;
  assign cnt_go = (cur <= lim);
  assign r2 = {rem, ka[bitn]};
  // Divide by ten through the reciprocal; exact for every 16-bit value.
  assign prod = 33'(tdig) * 33'd52429;
  assign quo = VAL_W'(prod >> 19);
  assign digit = 4'(tdig - ((quo << 3) + (quo << 1)));
  assign rev_w = (21'(rev) << 3) + (21'(rev) << 1) + 21'(digit);
  assign rev_v = VW'(rev);
  assign emit_go = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa[AW-1:0]] <= wd;
    end
    rdata <= mem[ra[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL:  if (cur == TS_LAST) state_next = ST_SRD;
      ST_SRD:   state_next = (sq >= TS_V) ? ST_IDLE : ST_SCHK;
      ST_SCHK:  state_next = rdata ? ST_SMARK : ST_SRD;
      ST_SMARK: if (m + cur >= TS_V) state_next = ST_SRD;
      ST_IDLE: begin
        if (q_valid) begin
          unique case (query.op)
            OP_RANGE, OP_BELOW: state_next = ST_CNT;
            OP_DIV:     state_next = (query.a < 16'd2) ? ST_EMIT : ST_DCHK;
            OP_ISPRIME: state_next = (VW'(query.a) >= TS_V) ? ST_EMIT : ST_PCHK;
            OP_REV:     state_next = ST_REV;
            OP_NEAR:    state_next = ST_NK;
            default:    state_next = ST_EMIT;
          endcase
        end
      end
      ST_CNT:   if (!cnt_go && !pend) state_next = ST_EMIT;
      ST_DCHK:  state_next = (sq > kv) ? ST_EMIT : ST_DDIV;
      ST_DDIV:  if (bitn == 4'd0) state_next = ST_DRES;
      ST_DRES:  state_next = (rem == 9'd0) ? ST_EMIT : ST_DCHK;
      ST_PCHK:  state_next = ST_EMIT;
      ST_REV: begin
        if (tdig == '0) begin
          state_next = (rev_v >= TS_V) ? ST_EMIT : ST_RRD;
        end
      end
      ST_RRD:   state_next = ST_PCHK;
      ST_NK:    state_next = ((kv < TS_V) && rdata) ? ST_EMIT : ST_NLO;
      ST_NLO:   state_next = ST_NHI;
      ST_NHI:   state_next = ST_NCHK;
      ST_NCHK: begin
        if (hi_p || lof || step == NEAR_LAST) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_NLO;
        end
      end
      ST_EMIT:  if (emit_go && !has2) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    we = 1'b0;
    wa = cur;
    wd = 1'b0;
    ra = cur;
    unique case (state)
      ST_FILL: begin
        we = 1'b1;
        wd = (cur >= VW'(2));
      end
      ST_SMARK: begin
        we = 1'b1;
        wa = m;
      end
      ST_IDLE: begin
        q_ready = 1'b1;
        ra = VW'(query.a);
      end
      ST_RRD:  ra = rev_v;
      ST_NLO:  ra = lo_v;
      ST_NHI:  ra = hi_v;
      default: ra = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      cur <= '0;
      pend <= 1'b0;
      has2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_FILL: begin
          if (cur == TS_LAST) begin
            cur <= VW'(2);
            sq <= VW'(4);
          end else begin
            cur <= cur + 1'b1;
          end
        end
        ST_SRD: ;
        ST_SCHK: begin
          if (rdata) begin
            m <= sq;
          end else begin
            cur <= cur + 1'b1;
            sq <= sq + (cur << 1) + 1'b1;
          end
        end
        ST_SMARK: begin
          m <= m + cur;
          if (m + cur >= TS_V) begin
            cur <= cur + 1'b1;
            sq <= sq + (cur << 1) + 1'b1;
          end
        end
        ST_IDLE: begin
          ka <= query.a;
          kv <= VW'(query.a);
          acc <= '0;
          pend <= 1'b0;
          has2 <= 1'b0;
          res_last <= 1'b1;
          res_oor <= 1'b0;
          res_ans <= (query.op == OP_DIV) ? ANS_W'(query.a) : '0;
          dv <= 9'd2;
          sq <= VW'(4);
          tdig <= query.a;
          rev <= '0;
          step <= ANS_W'(1);
          if (query.op == OP_BELOW) begin
            if (query.a == '0) begin
              cur <= VW'(1);
              lim <= '0;
            end else begin
              cur <= '0;
              lim <= (VW'(query.a) - 1'b1 > TS_LAST) ? TS_LAST : VW'(query.a) - 1'b1;
            end
          end else begin
            cur <= VW'(query.a);
            lim <= (VW'(query.b) > TS_LAST) ? TS_LAST : VW'(query.b);
          end
        end
        ST_CNT: begin
          if (pend && rdata) begin
            acc <= acc + 1'b1;
          end
          pend <= cnt_go;
          if (cnt_go) begin
            cur <= cur + 1'b1;
          end else if (!pend) begin
            res_ans <= acc;
          end
        end
        ST_DCHK: begin
          rem <= '0;
          bitn <= 4'd15;
          res_ans <= ANS_W'(ka);
        end
        ST_DDIV: begin
          rem <= (r2 >= 10'(dv)) ? 9'(r2 - 10'(dv)) : r2[8:0];
          bitn <= bitn - 1'b1;
        end
        ST_DRES: begin
          if (rem == 9'd0) begin
            res_ans <= ANS_W'(dv);
          end else begin
            dv <= dv + 1'b1;
            sq <= sq + VW'({dv, 1'b0}) + VW'(1);
          end
        end
        ST_PCHK: res_ans <= ANS_W'(rdata);
        ST_REV: begin
          if (tdig == '0) begin
            if (rev_v >= TS_V) begin
              res_oor <= 1'b1;
            end
          end else begin
            rev <= rev_w[ANS_W-1:0];
            tdig <= quo;
          end
        end
        ST_RRD: ;
        ST_NK: res_ans <= ANS_W'(kv);
        ST_NLO: ;
        ST_NHI: lof <= lo_ok && rdata;
        ST_NCHK: begin
          step <= step + 1'b1;
          if (hi_p && lof) begin
            res_ans <= ANS_W'(lo_v);
            res_last <= 1'b0;
            has2 <= 1'b1;
            ans2 <= ANS_W'(hi_v);
          end else if (hi_p) begin
            res_ans <= ANS_W'(hi_v);
          end else if (lof) begin
            res_ans <= ANS_W'(lo_v);
          end else begin
            res_ans <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            answer <= res_ans;
            last <= res_last;
            out_of_range <= res_oor;
            if (has2) begin
              has2 <= 1'b0;
              res_ans <= ans2;
              res_last <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/prime_table_query_engine_unit.sv -----
// Reset runs the sieve: the whole map is filled first, then the multiples of each prime are
// marked; queries wait in the input queue until it finishes. A smallest-divisor query tries
// at most 254 trial divisors. One query is in the back end at a time, one map read a cycle on
// the single read port; the next transaction is taken while a result waits.
module prime_table_query_engine_unit #(
  parameter int TABLE_SIZE = ptq_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mode[2:0], first_value[18:3], second_value[34:19]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // answer[16:0]
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // out_of_range[0]
);
  import ptq_pkg::*;

  query_t           query;
  logic             q_valid;
  logic             q_ready;
  logic [ANS_W-1:0] answer;
  logic             oor;

  ptq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .mode         (s_axis_tdata[2:0]),
    .first_value  (s_axis_tdata[18:3]),
    .second_value (s_axis_tdata[34:19]),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .query        (query)
  );

  ptq_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .query        (query),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .answer       (answer),
    .last         (m_axis_tlast),
    .out_of_range (oor)
  );

  assign m_axis_tdata = {7'd0, answer};
  assign m_axis_tuser = oor;

`ifndef SYNTHESIS
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[16:0] == '0 && m_axis_tlast)
    else $error("out_of_range result carries a nonzero answer or is not last");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid ##0
    m_axis_tdata[16:0] > $past(m_axis_tdata[16:0]))
    else $error("second nearest prime did not follow the first");

  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid && $stable(query))
    else $error("queued query changed while waiting");
`endif

endmodule
